// ===== hdl/mpct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared types and constants of the mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package mpct_pkg;

    localparam int unsigned COORD_W = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned BTN_W   = 2;
    localparam int unsigned NUM_BTN = 3;
    localparam int unsigned MAX_EV  = NUM_BTN + 1;
    localparam int unsigned CNT_W   = $clog2(MAX_EV + 1);

    // event codes
    localparam logic [KIND_W-1:0] EV_MOVE    = 2'd0;
    localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

    // configuration register indexes
    localparam logic CFG_MAX_COLUMN = 1'b0;
    localparam logic CFG_MAX_ROW    = 1'b1;

    localparam logic [COORD_W-1:0] RESET_MAX_COLUMN = 8'd79;
    localparam logic [COORD_W-1:0] RESET_MAX_ROW    = 8'd24;
    localparam logic [COORD_W-1:0] RESET_COLUMN     = 8'd40;
    localparam logic [COORD_W-1:0] RESET_ROW        = 8'd12;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [BTN_W-1:0]   button_number;
        logic [COORD_W-1:0] old_column;
        logic [COORD_W-1:0] old_row;
        logic [COORD_W-1:0] new_column;
        logic [COORD_W-1:0] new_row;
        logic               last_event;
    } t_event;

endpackage

// ===== hdl/mpct_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_in_if
// Byte channel from the controller: auxiliary flag and data byte.
// ----------------------------------------------------------------------------
interface mpct_in_if;
    logic       valid;
    logic       ready;
    logic       aux_flag;
    logic [7:0] data_byte;

    modport source (output valid, output aux_flag, output data_byte, input ready);
    modport sink   (input valid, input aux_flag, input data_byte, output ready);
endinterface

// ===== hdl/mpct_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_out_if
// Event channel: move and button events with cursor positions.
// ----------------------------------------------------------------------------
interface mpct_out_if;
    logic                                valid;
    logic                                ready;
    logic [mpct_pkg::KIND_W-1:0]         event_kind;
    logic [mpct_pkg::BTN_W-1:0]          button_number;
    logic [mpct_pkg::COORD_W-1:0]        old_column;
    logic [mpct_pkg::COORD_W-1:0]        old_row;
    logic [mpct_pkg::COORD_W-1:0]        new_column;
    logic [mpct_pkg::COORD_W-1:0]        new_row;
    logic                                last_event;

    modport source (output valid, output event_kind, output button_number,
                    output old_column, output old_row, output new_column,
                    output new_row, output last_event, input ready);
    modport sink   (input valid, input event_kind, input button_number,
                    input old_column, input old_row, input new_column,
                    input new_row, input last_event, output ready);
endinterface

// ===== hdl/mouse_packet_cursor_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker
// Assembles three-byte mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// A byte is taken into an input register in any cycle that register is free,
// so bytes flow at one per cycle while no packet byte waits there. The third
// byte of a packet is decoded in a single pass into up to four events (one
// move, then a press or release per changed button) that load a four-entry
// event buffer when the byte leaves the input register; the buffer hands out
// one event per cycle while the event channel is ready. A packet byte that
// yields events waits in the input register until the buffer is empty or its
// last entry is leaving, so it can wait while the previous packet's events
// drain or the event channel stalls. Untagged bytes and the first two bytes
// of a packet never wait.
module mouse_packet_cursor_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [mpct_pkg::COORD_W-1:0] i_cfg_data,
    mpct_in_if.sink                      i_byte,
    mpct_out_if.source                   o_event
);

    localparam int unsigned W  = mpct_pkg::COORD_W;
    localparam int unsigned NE = mpct_pkg::MAX_EV;
    localparam int unsigned CW = mpct_pkg::CNT_W;

    // configuration
    logic [W-1:0] r_max_column;
    logic [W-1:0] r_max_row;

    // input register
    logic         r_in_valid;
    logic         r_in_flag;
    logic [7:0]   r_in_data;

    // packet state
    logic [1:0]   r_byte_index;
    logic [7:0]   r_store0;
    logic [7:0]   r_store1;
    logic [W-1:0] r_column;
    logic [W-1:0] r_row;
    logic [2:0]   r_buttons;

    // event buffer, head at entry 0
    mpct_pkg::t_event r_ev [NE];
    logic [CW-1:0]    r_cnt;

    // decode
    logic                    final_byte;
    logic                    moved;
    logic signed [W+1:0]     col_sum;
    logic signed [W+1:0]     row_sum;
    logic [W-1:0]            n_column;
    logic [W-1:0]            n_row;
    logic [NE-1:0]           cand_v;
    mpct_pkg::t_event        cand [NE];
    mpct_pkg::t_event        packed_ev [NE];
    logic [CW-1:0]           n_events;
    logic                    pop;
    logic                    can_load;
    logic                    consume;

    always_comb begin
        final_byte = r_in_valid && r_in_flag && (r_byte_index >= 2'd2);
        moved      = (r_store1 != 8'd0) || (r_in_data != 8'd0);

        col_sum = $signed({2'b00, r_column}) + $signed({{2{r_store1[7]}}, r_store1});
        row_sum = $signed({2'b00, r_row}) - $signed({{2{r_in_data[7]}}, r_in_data});

        if (!moved) begin
            n_column = r_column;
        end else if (col_sum < 0) begin
            n_column = '0;
        end else if (col_sum[W:0] > {1'b0, r_max_column}) begin
            n_column = r_max_column;
        end else begin
            n_column = col_sum[W-1:0];
        end

        if (!moved) begin
            n_row = r_row;
        end else if (row_sum < 0) begin
            n_row = '0;
        end else if (row_sum[W:0] > {1'b0, r_max_row}) begin
            n_row = r_max_row;
        end else begin
            n_row = row_sum[W-1:0];
        end

        cand_v[0]              = moved;
        cand[0].event_kind     = mpct_pkg::EV_MOVE;
        cand[0].button_number  = '0;
        cand[0].old_column     = r_column;
        cand[0].old_row        = r_row;
        cand[0].new_column     = n_column;
        cand[0].new_row        = n_row;
        cand[0].last_event     = 1'b0;
        for (int b = 0; b < mpct_pkg::NUM_BTN; b++) begin
            cand_v[b+1]             = r_store0[b] != r_buttons[b];
            cand[b+1].event_kind    = r_buttons[b] ? mpct_pkg::EV_RELEASE
                                                   : mpct_pkg::EV_PRESS;
            cand[b+1].button_number = mpct_pkg::BTN_W'(b + 1);
            cand[b+1].old_column    = n_column;
            cand[b+1].old_row       = n_row;
            cand[b+1].new_column    = n_column;
            cand[b+1].new_row       = n_row;
            cand[b+1].last_event    = 1'b0;
        end

        // last flag: no later candidate present
        for (int j = 0; j < NE; j++) begin
            cand[j].last_event = cand_v[j] && ((cand_v >> (j + 1)) == '0);
        end

        // compact present candidates to the front
        n_events = '0;
        for (int j = 0; j < NE; j++) begin
            packed_ev[j] = cand[j];
        end
        for (int j = 0; j < NE; j++) begin
            if (cand_v[j]) begin
                packed_ev[n_events[CW-2:0]] = cand[j];
                n_events = n_events + 1'b1;
            end
        end
        if (!final_byte) begin
            n_events = '0;
        end

        pop      = o_event.valid && o_event.ready;
        can_load = (r_cnt == '0) || ((r_cnt == CW'(1)) && pop);
        consume  = r_in_valid && ((n_events == '0) || can_load);
    end

    assign i_byte.ready = !r_in_valid || consume;

    assign o_event.valid         = r_cnt != '0;
    assign o_event.event_kind    = r_ev[0].event_kind;
    assign o_event.button_number = r_ev[0].button_number;
    assign o_event.old_column    = r_ev[0].old_column;
    assign o_event.old_row       = r_ev[0].old_row;
    assign o_event.new_column    = r_ev[0].new_column;
    assign o_event.new_row       = r_ev[0].new_row;
    assign o_event.last_event    = r_ev[0].last_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_column <= mpct_pkg::RESET_MAX_COLUMN;
            r_max_row    <= mpct_pkg::RESET_MAX_ROW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mpct_pkg::CFG_MAX_COLUMN: r_max_column <= i_cfg_data;
                mpct_pkg::CFG_MAX_ROW:    r_max_row    <= i_cfg_data;
                default:                  r_max_row    <= r_max_row;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_flag <= i_byte.aux_flag;
            r_in_data <= i_byte.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_column     <= mpct_pkg::RESET_COLUMN;
            r_row        <= mpct_pkg::RESET_ROW;
            r_buttons    <= '0;
        end else if (consume && r_in_flag) begin
            if (final_byte) begin
                r_byte_index <= '0;
                r_column     <= n_column;
                r_row        <= n_row;
                r_buttons    <= r_store0[2:0];
            end else begin
                r_byte_index <= r_byte_index + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_in_flag && !final_byte) begin
            if (r_byte_index == 2'd0) begin
                r_store0 <= r_in_data;
            end else begin
                r_store1 <= r_in_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (consume && (n_events != '0)) begin
            r_cnt <= n_events;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && (n_events != '0)) begin
            for (int j = 0; j < NE; j++) begin
                r_ev[j] <= packed_ev[j];
            end
        end else if (pop) begin
            for (int j = 0; j < NE - 1; j++) begin
                r_ev[j] <= r_ev[j+1];
            end
        end
    end

endmodule
